/* hw/rtl/utx_pkg.sv */
// ----------------------------------------------------------------------------
// utx_pkg: shared types for the UTF-8 / UCS-2BE transcoder
// Decoder state, result groups and status codes used by the decode logic and
// by the top level.
// ----------------------------------------------------------------------------
package utx_pkg;

  typedef enum logic [1:0] {
    ST_CONV = 2'd0,
    ST_NUL  = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  // limit on the next UTF-8 continuation byte
  typedef enum logic [1:0] {
    LEAD_ANY = 2'd0,  // 0x80..0xBF
    LEAD_E0  = 2'd1,  // 0xA0..0xBF
    LEAD_ED  = 2'd2   // 0x80..0x9F
  } lead_t;

  typedef struct packed {
    logic [15:0] partial;
    logic [1:0]  pending;
    lead_t       lead;
    logic        stopped;
  } dec_state_t;

  // all result bytes that one input item causes, in order b0, b1, b2
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;     // 0 means no result
    logic       bval;
    status_t    status;
  } group_t;

  localparam dec_state_t STATE_CLEAR = '{partial: 16'h0000, pending: 2'd0,
                                         lead: LEAD_ANY, stopped: 1'b0};

endpackage

/* hw/rtl/utf8_ucs2be_transcoder.sv */
// ----------------------------------------------------------------------------
// utf8_ucs2be_transcoder: UTF-8 <-> UCS-2 big-endian byte-stream transcoder
// Converts one string at a time in the direction held in a mode register.
// Direction 0 decodes UTF-8 into UCS-2BE, direction 1 encodes UCS-2BE as
// UTF-8 of one to three bytes. A NUL or illegal input ends the string.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-----------------------------------
//   s_      | in  | s_tvalid/s_tready  | tdata: in_byte; tuser: start_string
//   m_      | out | m_tvalid/m_tready  | tdata: out_byte; tuser: byte_valid,
//           |     |                    | status; tlast: last
//   cfg_    | in  | cfg_valid/cfg_ready| cfg_data: direction
//
// An input byte is decoded in the cycle it is accepted; its result bytes are
// written as one group into a two-group queue and leave one byte per cycle
// while m_tready is high. A byte that gives two or three results holds the
// output until all of them are taken; the queue depth sets how far input runs
// ahead of a stalled output (two groups).
// Reset (rst, synchronous) empties the queue, sets direction 0 and clears the
// decoder. A direction write clears the decoder as well.
// ----------------------------------------------------------------------------
module utf8_ucs2be_transcoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tuser,   // [0] start_string
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [2:0] m_tuser,   // [0] byte_valid, [2:1] status
  output logic       m_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data   // [0] direction
);

  logic                direction;
  utx_pkg::dec_state_t state;
  utx_pkg::dec_state_t state_next;
  utx_pkg::group_t     group;

  // result group queue
  utx_pkg::group_t     queue [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          qcount;
  logic [1:0]          pos;     // byte within the head group
  utx_pkg::group_t     head;

  logic                s_fire;
  logic                m_fire;
  logic                push;
  logic                pop;

  utx_decode u_decode (
    .direction    (direction),
    .in_byte      (s_tdata),
    .start_string (s_tuser),
    .state        (state),
    .state_next   (state_next),
    .group        (group)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (qcount != 2'd2);
  assign s_fire    = s_tvalid && s_tready;
  assign push      = s_fire && (group.cnt != 2'd0);

  assign head      = queue[rd_ptr];
  assign m_tvalid  = (qcount != 2'd0);
  assign m_tlast   = (pos == (head.cnt - 2'd1));
  assign m_tuser   = {head.status, head.bval};
  assign m_fire    = m_tvalid && m_tready;
  assign pop       = m_fire && m_tlast;

  always_comb begin
    case (pos)
      2'd1:    m_tdata = head.b1;
      2'd2:    m_tdata = head.b2;
      default: m_tdata = head.b0;
    endcase
  end

  // mode register and decoder state; a mode write starts a fresh string
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      state     <= utx_pkg::STATE_CLEAR;
    end else if (cfg_valid) begin
      direction <= cfg_data;
      state     <= utx_pkg::STATE_CLEAR;
    end else if (s_fire) begin
      state     <= state_next;
    end
  end

  // hold the group payload; no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      qcount <= 2'd0;
      pos    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        pos    <= 2'd0;
      end else if (m_fire) begin
        pos    <= pos + 2'd1;  // advance to the next byte of the group
      end
      case ({push, pop})
        2'b10:   qcount <= qcount + 2'd1;
        2'b01:   qcount <= qcount - 2'd1;
        default: qcount <= qcount;
      endcase
    end
  end

  // the queue never holds more than two groups
  a_qcount_max: assert property (@(posedge clk) disable iff (rst)
    qcount != 2'd3)
    else $error("result queue overflow");

  // the byte position stays inside the head group
  a_pos_in_group: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pos < head.cnt))
    else $error("byte position beyond head group");

  // a stopped string holds no partial sequence
  a_stopped_clean: assert property (@(posedge clk) disable iff (rst)
    state.stopped |-> (state.pending == 2'd0))
    else $error("stopped with bytes pending");

  // a byte taken while stopped and without a start flag adds no group
  a_stopped_silent: assert property (@(posedge clk) disable iff (rst)
    (s_fire && state.stopped && !s_tuser && !cfg_valid) |-> !push)
    else $error("result produced after string end");

  // a write position only moves with a push
  a_wr_ptr_push: assert property (@(posedge clk) disable iff (rst)
    !push |=> $stable(wr_ptr))
    else $error("queue write pointer moved without push");

endmodule

/* hw/rtl/utx_decode.sv */
// ----------------------------------------------------------------------------
// utx_decode: per-byte transcode step
// Takes the decoder state and one source byte, gives the next state and the
// group of result bytes that the byte causes.
// ----------------------------------------------------------------------------
module utx_decode (
  input  logic                direction,
  input  logic [7:0]          in_byte,
  input  logic                start_string,
  input  utx_pkg::dec_state_t state,
  output utx_pkg::dec_state_t state_next,
  output utx_pkg::group_t     group
);

  utx_pkg::dec_state_t cur;
  logic [15:0]         shifted;
  logic [15:0]         unit;
  logic [1:0]          pend_dec;
  logic                in_range;
  logic                emit;
  logic [7:0]          e_hi;
  logic [7:0]          e_lo;
  utx_pkg::status_t    e_st;

  assign cur      = start_string ? utx_pkg::STATE_CLEAR : state;
  assign shifted  = {cur.partial[9:0], in_byte[5:0]};
  assign unit     = {cur.partial[7:0], in_byte};
  assign pend_dec = cur.pending - 2'd1;

  always_comb begin
    case (cur.lead)
      utx_pkg::LEAD_E0: in_range = (in_byte >= 8'hA0) && (in_byte <= 8'hBF);
      utx_pkg::LEAD_ED: in_range = (in_byte >= 8'h80) && (in_byte <= 8'h9F);
      default:          in_range = (in_byte[7:6] == 2'b10);
    endcase
  end

  always_comb begin
    state_next = cur;
    group      = '0;
    emit       = 1'b0;
    e_hi       = 8'h00;
    e_lo       = 8'h00;
    e_st       = utx_pkg::ST_ERR;
    if (!cur.stopped) begin
      if (!direction) begin
        // UTF-8 in, UCS-2BE out
        if (cur.pending == 2'd0) begin
          if (in_byte == 8'h00) begin
            emit = 1'b1;
            e_st = utx_pkg::ST_NUL;
          end else if (in_byte < 8'h80) begin
            emit = 1'b1;
            e_lo = in_byte;
            e_st = utx_pkg::ST_CONV;
          end else if ((in_byte >= 8'hC2) && (in_byte <= 8'hDF)) begin
            state_next.partial = {11'd0, in_byte[4:0]};
            state_next.pending = 2'd1;
            state_next.lead    = utx_pkg::LEAD_ANY;
          end else if (in_byte[7:4] == 4'hE) begin
            state_next.partial = {12'd0, in_byte[3:0]};
            state_next.pending = 2'd2;
            if (in_byte == 8'hE0) begin
              state_next.lead = utx_pkg::LEAD_E0;
            end else if (in_byte == 8'hED) begin
              state_next.lead = utx_pkg::LEAD_ED;
            end else begin
              state_next.lead = utx_pkg::LEAD_ANY;
            end
          end else begin
            emit = 1'b1;
          end
        end else if (!in_range) begin
          emit = 1'b1;
        end else begin
          state_next.partial = shifted;
          state_next.pending = pend_dec;
          state_next.lead    = utx_pkg::LEAD_ANY;
          if (pend_dec == 2'd0) begin
            emit = 1'b1;
            // refuse surrogates and 0xFFFF
            if (!((shifted == 16'hFFFF) || (shifted[15:11] == 5'b11011))) begin
              e_hi = shifted[15:8];
              e_lo = shifted[7:0];
              e_st = utx_pkg::ST_CONV;
            end
          end
        end
        if (emit) begin
          group.b0     = e_hi;
          group.b1     = e_lo;
          group.cnt    = 2'd2;
          group.bval   = 1'b1;
          group.status = e_st;
          if (e_st != utx_pkg::ST_CONV) begin
            state_next.stopped = 1'b1;
            state_next.pending = 2'd0;
            state_next.lead    = utx_pkg::LEAD_ANY;
          end
        end
      end else begin
        // UCS-2BE in, UTF-8 out
        if (cur.pending == 2'd0) begin
          state_next.partial = {8'd0, in_byte};
          state_next.pending = 2'd1;
        end else begin
          state_next.partial = 16'h0000;
          state_next.pending = 2'd0;
          group.cnt          = 2'd1;
          group.bval         = 1'b1;
          group.status       = utx_pkg::ST_CONV;
          if ((unit[15:11] == 5'b11011) || (unit == 16'hFFFF)) begin
            group.bval         = 1'b0;
            group.status       = utx_pkg::ST_ERR;
            state_next.stopped = 1'b1;
          end else if (unit == 16'h0000) begin
            group.status       = utx_pkg::ST_NUL;
            state_next.stopped = 1'b1;
          end else if (unit < 16'h0080) begin
            group.b0 = unit[7:0];
          end else if (unit < 16'h0800) begin
            group.b0  = {3'b110, unit[10:6]};
            group.b1  = {2'b10, unit[5:0]};
            group.cnt = 2'd2;
          end else begin
            group.b0  = {4'hE, unit[15:12]};
            group.b1  = {2'b10, unit[11:6]};
            group.b2  = {2'b10, unit[5:0]};
            group.cnt = 2'd3;
          end
        end
      end
    end
  end

endmodule
